### design/route_split_shortest_path_unit_assert.svh
// Assertion macros shared by the route split unit.
// No dependencies; included by the modules that assert.
`ifndef ROUTE_SPLIT_SHORTEST_PATH_UNIT_ASSERT_SVH
`define ROUTE_SPLIT_SHORTEST_PATH_UNIT_ASSERT_SVH

// condition holds at every edge out of reset
`define RSSP_ASSERT_HOLD(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define RSSP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define RSSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/rssp_pkg.sv
// Package of the route split unit: widths, constants, store entry layout,
// and the command and status groups between controller and datapath.
package rssp_pkg;

	localparam int MAX_SEGMENT_DEF = 64;

	localparam int NODE_W = 6;
	localparam int DEM_W  = 16;
	localparam int DIST_W = 24;
	localparam int COST_W = 32;
	localparam int KEY_W  = COST_W + 2;

	localparam logic [DEM_W-1:0]  LIMIT_RESET = 16'd80;
	localparam logic [COST_W-1:0] SAT_COST    = 32'hFFFF_FFFF;

	// key = best cost before the start + depot leg - leg prefix at the start
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [DEM_W-1:0]  demand;
		logic              cand;
		logic [NODE_W-1:0] pred;
	} entry_t;

	typedef struct packed {
		logic accept;
		logic start;
		logic scan;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic stored;
		logic scan_end;
		logic out_free;
	} stat_t;

endpackage

### design/rssp_ctrl.sv
// Controller of the route split unit: sequences accept, store write,
// candidate scan and result hand-off. Depends on rssp_pkg.
module rssp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  rssp_pkg::stat_t stat,
	output rssp_pkg::cmd_t  cmd
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_WRITE  = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_TAIL   = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd       = '0;
		in_stall  = 1'b1;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = ST_WRITE;
				end
			end
			ST_WRITE: begin
				cmd.start = 1'b1;
				state_nxt = stat.stored ? ST_SCAN : ST_FINISH;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_end) begin
					state_nxt = ST_TAIL;
				end
			end
			ST_TAIL: begin
				state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

### design/rssp_datapath.sv
// Datapath of the route split unit: item registers, trip start store,
// candidate evaluation pipeline, best tracking and result register.
// Depends on rssp_pkg and route_split_shortest_path_unit_assert.svh.
`include "route_split_shortest_path_unit_assert.svh"

module rssp_datapath #(
	parameter int MAX_SEGMENT = rssp_pkg::MAX_SEGMENT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rssp_pkg::cmd_t                 cmd,
	output rssp_pkg::stat_t                stat,
	input  logic                           cfg_write,
	input  logic [rssp_pkg::DEM_W-1:0]     cfg_data,
	input  logic                           first_in_segment,
	input  logic                           last_in_segment,
	input  logic [rssp_pkg::NODE_W-1:0]    depot_node,
	input  logic [rssp_pkg::NODE_W-1:0]    customer_node,
	input  logic [rssp_pkg::DEM_W-1:0]     demand,
	input  logic [rssp_pkg::DIST_W-1:0]    depot_to_customer,
	input  logic [rssp_pkg::DIST_W-1:0]    customer_to_depot,
	input  logic [rssp_pkg::DIST_W-1:0]    from_previous,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [rssp_pkg::NODE_W-1:0]    served_node,
	output logic                           reachable,
	output logic [rssp_pkg::COST_W-1:0]    best_cost,
	output logic [rssp_pkg::NODE_W-1:0]    predecessor_node,
	output logic                           segment_done
);

	localparam int AW = $clog2(MAX_SEGMENT);
	localparam int CW = $clog2(MAX_SEGMENT + 1);
	localparam int LW = rssp_pkg::DEM_W + CW;
	localparam int CO = rssp_pkg::COST_W;
	localparam int KW = rssp_pkg::KEY_W;
	localparam int NW = rssp_pkg::NODE_W;

	// configuration
	logic [rssp_pkg::DEM_W-1:0] limit_q;

	// segment state
	logic [CW-1:0] count_q;
	logic [CO-1:0] run_q;

	// current request
	logic [AW-1:0]               p_q;
	logic                        stored_q;
	logic [CO:0]                 a_q;
	logic [CO:0]                 qsum_q;
	logic [NW-1:0]               node_q;
	logic [NW-1:0]               depot_q;
	logic [rssp_pkg::DEM_W-1:0]  demand_q;
	logic [rssp_pkg::DIST_W-1:0] dback_q;
	logic                        last_q;

	// previous stored entry of the segment
	logic [CO-1:0] last_best_q;
	logic          last_reach_q;
	logic [NW-1:0] last_node_q;

	// trip start store and scan
	rssp_pkg::entry_t mem [MAX_SEGMENT];
	rssp_pkg::entry_t rd_q;
	logic [AW-1:0]    scan_addr_q;
	logic             issue_left_q;
	logic             e_valid_q;
	logic [AW-1:0]    e_addr_q;
	logic             halt_q;
	logic [LW-1:0]    load_q;

	logic          s2_valid_s2;
	logic [CO-1:0] total_s2;
	logic [NW-1:0] pred_s2;

	logic          found_q;
	logic [CO-1:0] best_q;
	logic [NW-1:0] pred_q;

	// accept-cycle logic
	logic [CW-1:0] cnt_eff;
	logic [CO:0]   run_sum;
	logic [CO-1:0] run_sat;
	logic [CO-1:0] run_eff;
	logic [CO-1:0] base_in;
	logic          stored_in;
	logic [CO:0]   a_in;

	// write and evaluation logic
	logic [KW-1:0]    key_w;
	rssp_pkg::entry_t wr_entry;
	logic             rd_en;
	logic             ev;
	logic [LW-1:0]    ld_next;
	logic             over;
	logic             scan_end;
	logic [KW:0]      sum_e;
	logic [CO-1:0]    total_e;

	assign cnt_eff   = first_in_segment ? '0 : count_q;
	assign run_sum   = {1'b0, run_q} + (CO + 1)'(from_previous);
	assign run_sat   = run_sum[CO] ? rssp_pkg::SAT_COST : run_sum[CO-1:0];
	assign run_eff   = first_in_segment ? '0 : ((count_q != '0) ? run_sat : run_q);
	assign base_in   = (cnt_eff == '0) ? '0 : last_best_q;
	assign stored_in = cnt_eff < CW'(MAX_SEGMENT);
	assign a_in      = {1'b0, base_in} + (CO + 1)'(depot_to_customer);

	assign key_w           = {1'b0, a_q} - {2'b00, run_q};
	assign wr_entry.key    = key_w;
	assign wr_entry.demand = demand_q;
	assign wr_entry.cand   = (p_q == '0) || last_reach_q;
	assign wr_entry.pred   = last_node_q;

	assign rd_en    = cmd.scan && issue_left_q && !halt_q;
	assign ev       = e_valid_q && !halt_q;
	assign ld_next  = load_q + LW'(rd_q.demand);
	assign over     = ld_next > LW'(limit_q);
	assign scan_end = ev && (over || (e_addr_q == '0));
	assign sum_e    = {rd_q.key[KW-1], rd_q.key} + {2'b00, qsum_q};
	assign total_e  = (sum_e[KW:CO] != '0) ? rssp_pkg::SAT_COST : sum_e[CO-1:0];

	assign stat.stored   = stored_q;
	assign stat.scan_end = scan_end;
	assign stat.out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= rssp_pkg::LIMIT_RESET;
		end else if (cfg_write) begin
			limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			run_q    <= '0;
			stored_q <= 1'b0;
		end else if (cmd.accept) begin
			count_q  <= stored_in ? cnt_eff + CW'(1) : cnt_eff;
			run_q    <= run_eff;
			stored_q <= stored_in;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			p_q      <= cnt_eff[AW-1:0];
			a_q      <= a_in;
			node_q   <= customer_node;
			depot_q  <= depot_node;
			demand_q <= demand;
			dback_q  <= customer_to_depot;
			last_q   <= last_in_segment;
		end
		if (cmd.start) begin
			qsum_q <= {1'b0, run_q} + (CO + 1)'(dback_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start && stored_q) begin
			mem[p_q] <= wr_entry;
		end
		if (rd_en) begin
			rd_q     <= mem[scan_addr_q];
			e_addr_q <= scan_addr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_addr_q  <= '0;
			issue_left_q <= 1'b0;
			e_valid_q    <= 1'b0;
			halt_q       <= 1'b0;
			load_q       <= '0;
			s2_valid_s2  <= 1'b0;
		end else begin
			e_valid_q   <= rd_en;
			s2_valid_s2 <= ev && !over && rd_q.cand;
			if (cmd.start) begin
				scan_addr_q  <= p_q;
				issue_left_q <= stored_q;
				halt_q       <= 1'b0;
				load_q       <= '0;
			end else begin
				if (rd_en) begin
					scan_addr_q <= scan_addr_q - AW'(1);
					if (scan_addr_q == '0) begin
						issue_left_q <= 1'b0;
					end
				end
				if (scan_end) begin
					halt_q <= 1'b1;
				end
				if (ev && !over) begin
					load_q <= ld_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		total_s2 <= total_e;
		pred_s2  <= (e_addr_q == '0) ? depot_q : rd_q.pred;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.start) begin
			found_q <= 1'b0;
		end else if (s2_valid_s2 && (!found_q || total_s2 <= best_q)) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd.start && s2_valid_s2 && (!found_q || total_s2 <= best_q)) begin
			best_q <= total_s2;
			pred_q <= pred_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_reach_q <= 1'b0;
		end else if (cmd.finish && stored_q) begin
			last_reach_q <= found_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish && stored_q) begin
			last_best_q <= best_q;
			last_node_q <= node_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.finish) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			served_node      <= node_q;
			reachable        <= found_q;
			best_cost        <= found_q ? best_q : '0;
			predecessor_node <= found_q ? pred_q : '0;
			segment_done     <= last_q;
		end
	end

	`RSSP_ASSERT_HOLD(a_count_bound, clk, arst_n, count_q <= CW'(MAX_SEGMENT),
		"segment count beyond store depth")
	`RSSP_ASSERT_IMPL(a_load_in_limit, clk, arst_n, cmd.scan, load_q <= LW'(limit_q),
		"accumulated trip load exceeds limit during scan")
	`RSSP_ASSERT_NEXT(a_cand_found, clk, arst_n, s2_valid_s2 && !cmd.start, found_q,
		"feasible candidate did not mark the customer reachable")
	`RSSP_ASSERT_NEXT(a_finish_out, clk, arst_n, cmd.finish, out_valid,
		"result register not loaded after finish")

endmodule

### design/route_split_shortest_path_unit.sv
// Top level of the route split unit: shortest-path trip split of a depot's
// customer sequence under a load limit. Depends on rssp_pkg, rssp_ctrl and
// rssp_datapath.
//
// Usage:
//   Requests enter on in_valid/in_stall, one customer per request in tour
//   order; results leave on out_valid/out_stall, one per request, in order.
//   cfg_write with cfg_data sets the trip load limit (80 after reset);
//   write it only while the unit is idle.
//   A request passes through the store write, the scan of its k trip starts,
//   a tail step and the result hand-off; a customer that finds the store
//   full skips the scan. The scan reads one stored start per cycle from the
//   start store, so k is at most the customer's position in its segment plus
//   one, at most MAX_SEGMENT. A new request is taken only after the previous
//   one has handed its result to the result register.
//   While out_stall is high the result register holds its request; the unit
//   accepts and works on the next request meanwhile and waits only to hand
//   its own result over.
//   Reset clears the segment count, the running leg sum and all control
//   state; the start store is not cleared.
module route_split_shortest_path_unit #(
	parameter int MAX_SEGMENT = rssp_pkg::MAX_SEGMENT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic [rssp_pkg::DEM_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        first_in_segment,
	input  logic                        last_in_segment,
	input  logic [rssp_pkg::NODE_W-1:0] depot_node,
	input  logic [rssp_pkg::NODE_W-1:0] customer_node,
	input  logic [rssp_pkg::DEM_W-1:0]  demand,
	input  logic [rssp_pkg::DIST_W-1:0] depot_to_customer,
	input  logic [rssp_pkg::DIST_W-1:0] customer_to_depot,
	input  logic [rssp_pkg::DIST_W-1:0] from_previous,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [rssp_pkg::NODE_W-1:0] served_node,
	output logic                        reachable,
	output logic [rssp_pkg::COST_W-1:0] best_cost,
	output logic [rssp_pkg::NODE_W-1:0] predecessor_node,
	output logic                        segment_done
);

	rssp_pkg::cmd_t  cmd;
	rssp_pkg::stat_t stat;

	rssp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	rssp_datapath #(
		.MAX_SEGMENT (MAX_SEGMENT)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.cfg_write         (cfg_write),
		.cfg_data          (cfg_data),
		.first_in_segment  (first_in_segment),
		.last_in_segment   (last_in_segment),
		.depot_node        (depot_node),
		.customer_node     (customer_node),
		.demand            (demand),
		.depot_to_customer (depot_to_customer),
		.customer_to_depot (customer_to_depot),
		.from_previous     (from_previous),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.served_node       (served_node),
		.reachable         (reachable),
		.best_cost         (best_cost),
		.predecessor_node  (predecessor_node),
		.segment_done      (segment_done)
	);

endmodule
